[rtl/lfsc_pkg.sv]
// Shared types, constants and register map of the line-follow steering controller.
`default_nettype none

package lfsc_pkg;

  localparam int unsigned LevelW  = 12;
  localparam int unsigned ThrW    = 13;
  localparam int unsigned SpeedW  = 5;
  localparam int unsigned HoldW   = 5;
  localparam int unsigned SettleW = 3;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned KeyW    = 2;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  typedef enum logic [1:0] {
    ActStop    = 2'd0,
    ActForward = 2'd1,
    ActLeft    = 2'd2,
    ActRight   = 2'd3
  } action_e;

  // remote key codes; codes 0 and 3 are ignored
  localparam logic [KeyW-1:0] KeyRaise = 2'd1;
  localparam logic [KeyW-1:0] KeyLower = 2'd2;

  localparam logic [DigitW-1:0] LedStraight = 4'd6;
  localparam logic [DigitW-1:0] LedLeft     = 4'd8;
  localparam logic [DigitW-1:0] LedRight    = 4'd1;

  localparam logic [ThrW-1:0] ThrMax   = 13'd4100;
  localparam logic [ThrW-1:0] ThrStep  = 13'd100;
  localparam logic [ThrW-1:0] ThrReset = 13'd2800;

  localparam logic [SpeedW-1:0]  DriveSpeedRst  = 5'd5;
  localparam logic [LevelW-1:0]  LiftLevelRst   = 12'd1000;
  localparam logic [HoldW-1:0]   HoldLimitRst   = 5'd20;
  localparam logic [SettleW-1:0] SettleLimitRst = 3'd4;

  // register index = paddr[3:2]
  localparam logic [1:0] RegDriveSpeed  = 2'd0;
  localparam logic [1:0] RegLiftLevel   = 2'd1;
  localparam logic [1:0] RegHoldLimit   = 2'd2;
  localparam logic [1:0] RegSettleLimit = 2'd3;

  typedef struct packed {
    logic [LevelW-1:0] left_level;
    logic [LevelW-1:0] right_level;
    logic [KeyW-1:0]   remote_key;
  } in_item_t;

  typedef struct packed {
    logic [SpeedW-1:0] left_speed;
    logic [SpeedW-1:0] right_speed;
    action_e           action_now;
    logic [DigitW-1:0] led_digit;
    logic [ThrW-1:0]   threshold_now;
  } out_item_t;

  typedef struct packed {
    logic [SpeedW-1:0]  drive_speed;
    logic [LevelW-1:0]  lift_level;
    logic [HoldW-1:0]   hold_limit;
    logic [SettleW-1:0] settle_limit;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/lfsc_stream_if.sv]
// Valid/ready item channel interface.
`default_nettype none

interface lfsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/line_follow_steering_controller_unit.sv]
// Line-follow steering controller: one control tick in, one drive command out.
// Each accepted item is a control tick with both ground sensor levels and a remote
// key. The tick is captured in an input register, decided against the threshold
// after its key and the stored drive history, and its result lands in an output
// register. A new tick is accepted every cycle while the output side takes results.
// The result shows on the output once it moves from the input register into the
// output register, and is taken at an edge where output ready is high. A stalled
// result stays in the output register; one more tick can then wait in the input
// register, after which input ready stays low until the result is taken. The drive
// speed, lift level, hold limit and settle limit are set through the APB port at
// byte addresses 0, 4, 8 and 12, and must only be written while no tick is in flight.
`default_nettype none

module line_follow_steering_controller_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  lfsc_stream_if.sink                       in_i,
  lfsc_stream_if.source                     out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lfsc_pkg::PaddrW-1:0]  paddr,
  input  wire logic [lfsc_pkg::PdataW-1:0]  pwdata,
  output logic      [lfsc_pkg::PdataW-1:0]  prdata,
  output logic                              pready
);
  import lfsc_pkg::*;

  cfg_t      cfg;
  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      out_vld_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      advance;

  lfsc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the decided tick moves into the output register
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  lfsc_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.data;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_item_q;

endmodule

`default_nettype wire

[rtl/lfsc_cfg_regs.sv]
// APB configuration registers of the steering controller.
`default_nettype none

module lfsc_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lfsc_pkg::PaddrW-1:0]  paddr,
  input  wire logic [lfsc_pkg::PdataW-1:0]  pwdata,
  output logic      [lfsc_pkg::PdataW-1:0]  prdata,
  output logic                              pready,
  output lfsc_pkg::cfg_t                    cfg_o
);
  import lfsc_pkg::*;

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegDriveSpeed:  cfg_d.drive_speed  = pwdata[SpeedW-1:0];
        RegLiftLevel:   cfg_d.lift_level   = pwdata[LevelW-1:0];
        RegHoldLimit:   cfg_d.hold_limit   = pwdata[HoldW-1:0];
        RegSettleLimit: cfg_d.settle_limit = pwdata[SettleW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_speed  <= DriveSpeedRst;
      cfg_q.lift_level   <= LiftLevelRst;
      cfg_q.hold_limit   <= HoldLimitRst;
      cfg_q.settle_limit <= SettleLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      RegDriveSpeed:  prdata = {{(PdataW-SpeedW){1'b0}}, cfg_q.drive_speed};
      RegLiftLevel:   prdata = {{(PdataW-LevelW){1'b0}}, cfg_q.lift_level};
      RegHoldLimit:   prdata = {{(PdataW-HoldW){1'b0}}, cfg_q.hold_limit};
      RegSettleLimit: prdata = {{(PdataW-SettleW){1'b0}}, cfg_q.settle_limit};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/lfsc_step.sv]
// Per-tick decision logic and controller history registers.
`default_nettype none

module lfsc_step (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire lfsc_pkg::in_item_t   item_i,
  input  wire lfsc_pkg::cfg_t       cfg_i,
  output lfsc_pkg::out_item_t       result_o
);
  import lfsc_pkg::*;

  logic [ThrW-1:0]    thr_q, thr_d;
  action_e            last_q, last_d;
  logic [HoldW-1:0]   hold_q, hold_d;
  logic [SettleW-1:0] settle_q, settle_d;

  action_e act;
  logic    lblack, rblack, lifted, turning;

  // threshold after this tick's key
  always_comb begin
    case (item_i.remote_key)
      KeyRaise: thr_d = (thr_q < ThrMax) ? thr_q + ThrStep : thr_q;
      KeyLower: thr_d = (thr_q >= ThrStep) ? thr_q - ThrStep : '0;
      default:  thr_d = thr_q;
    endcase
  end

  assign lblack  = {1'b0, item_i.left_level} < thr_d;
  assign rblack  = {1'b0, item_i.right_level} < thr_d;
  assign lifted  = (item_i.left_level < cfg_i.lift_level) &&
                   (item_i.right_level < cfg_i.lift_level);
  assign turning = (last_q == ActLeft) || (last_q == ActRight);

  always_comb begin
    last_d   = last_q;
    hold_d   = hold_q;
    settle_d = settle_q;
    act      = ActStop;
    if (lifted) begin
      last_d = ActStop;
      hold_d = '0;
    end else if (lblack && rblack) begin
      // repeat the last move for a while, then give up
      if (hold_q < cfg_i.hold_limit) begin
        hold_d = hold_q + 1'b1;
        act    = last_q;
      end else begin
        last_d = ActStop;
      end
    end else if (lblack) begin
      last_d = ActRight;
      hold_d = '0;
      act    = ActRight;
    end else if (rblack) begin
      last_d = ActLeft;
      hold_d = '0;
      act    = ActLeft;
    end else if (turning && (settle_q < cfg_i.settle_limit)) begin
      settle_d = settle_q + 1'b1;
      act      = last_q;
    end else begin
      last_d   = ActForward;
      hold_d   = '0;
      settle_d = '0;
      act      = ActForward;
    end
  end

  always_comb begin
    result_o.left_speed    = '0;
    result_o.right_speed   = '0;
    result_o.action_now    = act;
    result_o.led_digit     = LedStraight;
    result_o.threshold_now = thr_d;
    case (act)
      ActForward: begin
        result_o.left_speed  = cfg_i.drive_speed;
        result_o.right_speed = cfg_i.drive_speed;
      end
      ActLeft: begin
        result_o.right_speed = cfg_i.drive_speed;
        result_o.led_digit   = LedLeft;
      end
      ActRight: begin
        result_o.left_speed = cfg_i.drive_speed;
        result_o.led_digit  = LedRight;
      end
      default: begin
        result_o.left_speed = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThrReset;
      last_q   <= ActStop;
      hold_q   <= '0;
      settle_q <= '0;
    end else if (step_i) begin
      thr_q    <= thr_d;
      last_q   <= last_d;
      hold_q   <= hold_d;
      settle_q <= settle_d;
    end
  end

endmodule

`default_nettype wire

[rtl/lfsc_checker.sv]
// Port-level checks of the steering controller, bound to the top level.
`default_nettype none

module lfsc_checker (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire lfsc_pkg::out_item_t  out_item_i
);
  import lfsc_pkg::*;

  a_thr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_item_i.threshold_now <= ThrMax)
    else $error("threshold above its ceiling");

  a_led_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (out_item_i.action_now == ActLeft && out_item_i.led_digit == LedLeft) ||
      (out_item_i.action_now == ActRight && out_item_i.led_digit == LedRight) ||
      (out_item_i.action_now == ActStop && out_item_i.led_digit == LedStraight) ||
      (out_item_i.action_now == ActForward && out_item_i.led_digit == LedStraight))
    else $error("led digit does not match action");

  a_stop_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_item_i.action_now == ActStop) |->
      (out_item_i.left_speed == '0 && out_item_i.right_speed == '0))
    else $error("wheels move on stop");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_item_i)))
    else $error("stalled result item changed");

endmodule

bind line_follow_steering_controller_unit lfsc_checker u_lfsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.data)
);

`default_nettype wire
